/* hw/rtl/ptp_pi_clock_servo_unit_assert.svh */
// Assertion macros for the clock servo unit.
`ifndef PTP_PI_CLOCK_SERVO_UNIT_ASSERT_SVH
`define PTP_PI_CLOCK_SERVO_UNIT_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define PTPSV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("servo assertion failed");

// next-cycle implication, checked while out of reset
`define PTPSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("servo assertion failed");

`endif

/* hw/rtl/ptpsv_pkg.sv */
`timescale 1ns / 1ps

package ptpsv_pkg;

  localparam logic [7:0]  MIN_FRAME_LEN  = 8'd44;
  localparam logic [47:0] MIN_VALID_SECS = 48'd1000000000;
  localparam logic [3:0]  MSG_SYNC       = 4'h0;
  localparam logic [3:0]  MSG_FOLLOW_UP  = 4'h8;
  localparam logic        OP_RESYNC      = 1'b1;

  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [9:0]  NS_PER_US = 10'd1000;
  // floor(ns / 1000) == (ns * DIV_MAGIC) >> DIV_SHIFT for every 32-bit ns
  localparam logic [28:0] DIV_MAGIC = 29'd274877907;
  localparam int          DIV_SHIFT = 38;

  // 2^64 = WRAP_Q * 10^6 + WRAP_R; only the low 32 bits of WRAP_Q are needed
  localparam logic [31:0] WRAP_Q_LO    = 32'd4154504685;
  localparam logic [23:0] WRAP_R       = 24'd551616;
  // 9 * 10^6 bias keeps the residue positive for up to 15 wraps
  localparam logic [23:0] V_BIAS       = 24'd9000000;
  localparam logic [31:0] Q_BIAS       = 32'd9;
  localparam int          V_DIGITS_MAX = 13;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN = 3'd0,
    CFG_INT_GAIN  = 3'd1,
    CFG_MAX_ADJ   = 3'd2,
    CFG_INT_LIMIT = 3'd3,
    CFG_STEP_THR  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SET  = 2'd1,
    ACT_ADJ  = 2'd2
  } action_e;

  typedef struct packed {
    logic [13:0] prop_gain;
    logic [13:0] int_gain;
    logic [26:0] max_adj;
    logic [29:0] int_limit;
    logic [39:0] step_thr;
  } cfg_t;

  typedef struct packed {
    logic    ld_in;
    logic    mul;
    logic    mst;
    logic    offs;
    logic    dec;
    logic    div_init;
    logic    div_step;
    logic    sat;
    logic    mult;
    logic    sum;
    logic    clamp;
    logic    load_out;
    action_e act;
  } cmd_t;

  typedef struct packed {
    logic resync;
    logic qual;
    logic hard;
  } status_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] set_seconds;
    logic [29:0] set_nanoseconds;
    logic [27:0] freq_adjust_ppb;
    logic [63:0] offset_us;
    logic [63:0] jitter_us;
    logic        synchronized;
  } res_t;

endpackage

/* hw/rtl/ptpsv_cfg_regs.sv */
`timescale 1ns / 1ps

module ptpsv_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [39:0]         cfg_data_i,
  output ptpsv_pkg::cfg_t     cfg_o
);

  ptpsv_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain <= 14'd100;
      cfg_q.int_gain  <= 14'd10;
      cfg_q.max_adj   <= 27'd1000000;
      cfg_q.int_limit <= 30'd1000000;
      cfg_q.step_thr  <= 40'd1000000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ptpsv_pkg::CFG_PROP_GAIN: cfg_q.prop_gain <= cfg_data_i[13:0];
        ptpsv_pkg::CFG_INT_GAIN:  cfg_q.int_gain  <= cfg_data_i[13:0];
        ptpsv_pkg::CFG_MAX_ADJ:   cfg_q.max_adj   <= cfg_data_i[26:0];
        ptpsv_pkg::CFG_INT_LIMIT: cfg_q.int_limit <= cfg_data_i[29:0];
        ptpsv_pkg::CFG_STEP_THR:  cfg_q.step_thr  <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/ptpsv_ctrl.sv */
`timescale 1ns / 1ps

module ptpsv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ptpsv_pkg::status_t status_i,
  output ptpsv_pkg::cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL   = 12'b0000_0000_0010,
    S_MST   = 12'b0000_0000_0100,
    S_OFFS  = 12'b0000_0000_1000,
    S_DEC   = 12'b0000_0001_0000,
    S_CMP   = 12'b0000_0010_0000,
    S_DIV   = 12'b0000_0100_0000,
    S_SAT   = 12'b0000_1000_0000,
    S_MULT  = 12'b0001_0000_0000,
    S_SUM   = 12'b0010_0000_0000,
    S_CLAMP = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_e;

  state_e                          state_q, state_d;
  ptpsv_pkg::action_e              act_q, act_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    cmd_o   = '0;
    cmd_o.act = act_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (status_i.resync || !status_i.qual) begin
          act_d   = ptpsv_pkg::ACT_NONE;
          state_d = S_DONE;
        end else begin
          state_d = S_MST;
        end
      end
      S_MST: begin
        cmd_o.mst = 1'b1;
        state_d   = S_OFFS;
      end
      S_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d    = S_DEC;
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (status_i.hard) begin
          cmd_o.div_init = 1'b1;
          act_d          = ptpsv_pkg::ACT_SET;
          state_d        = S_DIV;
        end else begin
          act_d   = ptpsv_pkg::ACT_ADJ;
          state_d = S_SAT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = S_DONE;
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ptpsv_pkg::ACT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/ptpsv_datapath.sv */
`timescale 1ns / 1ps

module ptpsv_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptpsv_pkg::cfg_t    cfg_i,
  input  ptpsv_pkg::cmd_t    cmd_i,
  output ptpsv_pkg::status_t status_o,
  input  logic               op_i,
  input  logic [7:0]         frame_length_i,
  input  logic [3:0]         message_type_i,
  input  logic [47:0]        master_seconds_i,
  input  logic [31:0]        master_nanoseconds_i,
  input  logic [62:0]        rx_time_us_i,
  output ptpsv_pkg::res_t    res_o
);

  // captured item
  logic        op_q;
  logic [7:0]  len_q;
  logic [3:0]  type_q;
  logic [47:0] secs_q;
  logic [31:0] ns_q;
  logic [62:0] local_q;

  // master time build-up
  logic [43:0] plo_q, phi_q;
  logic [60:0] uprod;
  logic [22:0] u_q;
  logic [3:0]  wrap_q;
  logic [63:0] master_q;

  logic [63:0] off_q, mag_q, jit_q;
  logic signed [41:0] acc_q;

  // divide by one million: fold the 2^64 wraps back, then one digit compare
  logic [23:0] wrap_r;
  logic [31:0] wrap_q_lo;
  logic [23:0] v_q;
  logic [31:0] qb_q;
  logic [3:0]  digit;
  logic [31:0] dq_q;
  logic [19:0] rem_q;

  logic signed [30:0] acc_sat_q, acc_sat_d;
  logic signed [55:0] p1_q;
  logic signed [45:0] p2_q;
  logic signed [56:0] adj_q;
  logic signed [56:0] max_p, max_n;
  logic [27:0]        freq_q, freq_d;
  logic signed [41:0] lim_p, lim_n;

  // servo state
  logic               sync_q;
  logic signed [31:0] integral_q;
  logic [63:0]        prev_q;

  ptpsv_pkg::res_t res_q, res_d;

  assign status_o.resync = (op_q == ptpsv_pkg::OP_RESYNC);
  assign status_o.qual   = (len_q >= ptpsv_pkg::MIN_FRAME_LEN) &&
                           ((type_q == ptpsv_pkg::MSG_SYNC) ||
                            (type_q == ptpsv_pkg::MSG_FOLLOW_UP)) &&
                           (secs_q > ptpsv_pkg::MIN_VALID_SECS);
  assign status_o.hard   = !sync_q || (mag_q > {24'd0, cfg_i.step_thr});

  assign uprod = ns_q * ptpsv_pkg::DIV_MAGIC;

  assign wrap_r    = 24'(wrap_q) * ptpsv_pkg::WRAP_R;
  assign wrap_q_lo = 32'(wrap_q) * ptpsv_pkg::WRAP_Q_LO;

  always_comb begin
    digit = '0;
    for (int j = 1; j <= ptpsv_pkg::V_DIGITS_MAX; j++) begin
      if (v_q >= 24'(j) * {4'd0, ptpsv_pkg::US_PER_S}) begin
        digit = 4'(j);
      end
    end
  end

  assign lim_p = $signed({12'd0, cfg_i.int_limit});
  assign lim_n = -lim_p;

  always_comb begin
    if (acc_q > lim_p) begin
      acc_sat_d = lim_p[30:0];
    end else if (acc_q < lim_n) begin
      acc_sat_d = lim_n[30:0];
    end else begin
      acc_sat_d = acc_q[30:0];
    end
  end

  assign max_p = $signed({30'd0, cfg_i.max_adj});
  assign max_n = -max_p;

  always_comb begin
    if (adj_q > max_p) begin
      freq_d = max_p[27:0];
    end else if (adj_q < max_n) begin
      freq_d = max_n[27:0];
    end else begin
      freq_d = adj_q[27:0];
    end
  end

  always_comb begin
    res_d              = '0;
    res_d.action       = cmd_i.act;
    res_d.synchronized = 1'b1;
    case (cmd_i.act)
      ptpsv_pkg::ACT_SET: begin
        res_d.set_seconds     = dq_q;
        res_d.set_nanoseconds = 30'(rem_q * ptpsv_pkg::NS_PER_US);
        res_d.offset_us       = off_q;
        res_d.jitter_us       = jit_q;
      end
      ptpsv_pkg::ACT_ADJ: begin
        res_d.freq_adjust_ppb = freq_q;
        res_d.offset_us       = off_q;
        res_d.jitter_us       = jit_q;
      end
      default: begin
        res_d.synchronized = status_o.resync ? 1'b0 : sync_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q    <= op_i;
      len_q   <= frame_length_i;
      type_q  <= message_type_i;
      secs_q  <= master_seconds_i;
      ns_q    <= master_nanoseconds_i;
      local_q <= rx_time_us_i;
    end
    if (cmd_i.mul) begin
      plo_q <= secs_q[23:0] * ptpsv_pkg::US_PER_S;
      phi_q <= secs_q[47:24] * ptpsv_pkg::US_PER_S;
      u_q   <= uprod[60:ptpsv_pkg::DIV_SHIFT];
    end
    if (cmd_i.mst) begin
      {wrap_q, master_q} <= {24'd0, plo_q} + {phi_q, 24'd0} + {45'd0, u_q};
    end
    if (cmd_i.offs) begin
      off_q <= master_q - {1'b0, local_q};
    end
    if (cmd_i.dec) begin
      mag_q <= off_q[63] ? (64'd0 - off_q) : off_q;
      jit_q <= (prev_q == 64'd0) ? 64'd0 : (off_q - prev_q);
      acc_q <= 42'(integral_q) + $signed(off_q[41:0]);
    end
    if (cmd_i.div_init) begin
      v_q  <= {1'b0, u_q} + ptpsv_pkg::V_BIAS - wrap_r;
      qb_q <= secs_q[31:0] - wrap_q_lo - ptpsv_pkg::Q_BIAS;
    end
    if (cmd_i.div_step) begin
      dq_q  <= qb_q + {28'd0, digit};
      rem_q <= 20'(v_q - 24'(digit) * {4'd0, ptpsv_pkg::US_PER_S});
    end
    if (cmd_i.sat) begin
      acc_sat_q <= acc_sat_d;
    end
    if (cmd_i.mult) begin
      p1_q <= $signed({1'b0, cfg_i.prop_gain}) * $signed(off_q[40:0]);
      p2_q <= $signed({1'b0, cfg_i.int_gain}) * acc_sat_q;
    end
    if (cmd_i.sum) begin
      adj_q <= 57'(p1_q) + 57'(p2_q);
    end
    if (cmd_i.clamp) begin
      freq_q <= freq_d;
    end
    if (cmd_i.load_out) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q     <= 1'b0;
      integral_q <= '0;
      prev_q     <= '0;
    end else if (cmd_i.load_out) begin
      case (cmd_i.act)
        ptpsv_pkg::ACT_SET: begin
          sync_q     <= 1'b1;
          integral_q <= '0;
          prev_q     <= off_q;
        end
        ptpsv_pkg::ACT_ADJ: begin
          sync_q     <= 1'b1;
          integral_q <= 32'(acc_sat_q);
          prev_q     <= off_q;
        end
        default: begin
          if (status_o.resync) begin
            sync_q <= 1'b0;
          end
        end
      endcase
    end
  end

  assign res_o = res_q;

endmodule

/* hw/rtl/ptp_pi_clock_servo_unit.sv */
`timescale 1ns / 1ps
// PTP PI clock servo. One result item per input item; the block works on one
// item at a time through a sequencer. A steered message passes the MUL, MST,
// OFFS, DEC, CMP, SAT, MULT, SUM and CLAMP states, a hard clock set the MUL,
// MST, OFFS, DEC, CMP and DIV states (the last two for the divide by one
// million) and a non-qualifying message or force resync only MUL, before
// DONE loads the result; the next item is accepted in the cycle after the
// result is loaded. The result sits in an output register, so the next item
// is accepted while it waits to be taken; a later result that is ready before
// then holds the sequencer until the register frees. Configuration writes are
// taken every cycle and must be made while idle.

`include "ptp_pi_clock_servo_unit_assert.svh"

module ptp_pi_clock_servo_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // frame_length[7:0], message_type[11:8], master_seconds[59:12],
  // master_nanoseconds[91:60], rx_time_us[154:92], zero fill
  input  logic [159:0] s_axis_tdata_i,
  // op[0]
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // set_seconds[31:0], set_nanoseconds[61:32], freq_adjust_ppb[89:62],
  // offset_us[153:90], jitter_us[217:154], synchronized[218], zero fill
  output logic [223:0] m_axis_tdata_o,
  // action[1:0]
  output logic [1:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [39:0]  cfg_data_i
);

  ptpsv_pkg::cfg_t    cfg;
  ptpsv_pkg::cmd_t    cmd;
  ptpsv_pkg::status_t status;
  ptpsv_pkg::res_t    res;

  ptpsv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ptpsv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ptpsv_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .cmd_i                (cmd),
    .status_o             (status),
    .op_i                 (s_axis_tuser_i[0]),
    .frame_length_i       (s_axis_tdata_i[7:0]),
    .message_type_i       (s_axis_tdata_i[11:8]),
    .master_seconds_i     (s_axis_tdata_i[59:12]),
    .master_nanoseconds_i (s_axis_tdata_i[91:60]),
    .rx_time_us_i         (s_axis_tdata_i[154:92]),
    .res_o                (res)
  );

  assign m_axis_tuser_o = res.action;
  assign m_axis_tdata_o = {5'd0, res.synchronized, res.jitter_us, res.offset_us,
                           res.freq_adjust_ppb, res.set_nanoseconds, res.set_seconds};

  `PTPSV_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `PTPSV_ASSERT_IMPL(a_none_has_no_offset, clk_i, rst_ni,
    m_axis_tvalid_o && (m_axis_tuser_o == ptpsv_pkg::ACT_NONE),
    (m_axis_tdata_o[217:90] == 128'd0) && (m_axis_tdata_o[89:0] == 90'd0))
  `PTPSV_ASSERT_IMPL(a_action_sets_sync, clk_i, rst_ni,
    m_axis_tvalid_o && ((m_axis_tuser_o == ptpsv_pkg::ACT_SET) ||
                        (m_axis_tuser_o == ptpsv_pkg::ACT_ADJ)),
    m_axis_tdata_o[218])
  `PTPSV_ASSERT_IMPL(a_freq_only_on_adjust, clk_i, rst_ni,
    m_axis_tvalid_o && (m_axis_tuser_o != ptpsv_pkg::ACT_ADJ),
    m_axis_tdata_o[89:62] == 28'd0)

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ptpsv_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam logic [63:0] US_PER_SEC     = 64'd1000000;
  localparam logic [47:0] SECS0          = 48'd1000000001;
  localparam logic [63:0] THR0           = 64'd1000000;

  typedef struct {
    bit          op;
    logic [7:0]  len;
    logic [3:0]  mtype;
    logic [47:0] secs;
    logic [31:0] ns;
    logic [62:0] lcl;
  } ptp_item_t;

  typedef struct {
    ptp_item_t it;
    bit        typed;
    res_t      want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [159:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tready = 1'b1;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [39:0] cfg_data = '0;
  logic s_axis_tready_o, m_axis_tvalid_o, cfg_ready_o;
  logic [223:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;

  // servo copy: configuration and state
  logic [13:0] cfg_prop = 14'd100;
  logic [13:0] cfg_int = 14'd10;
  logic [26:0] cfg_maxadj = 27'd1000000;
  logic [29:0] cfg_intlim = 30'd1000000;
  logic [39:0] cfg_stepthr = 40'd1000000;
  bit servo_synced = 1'b0;
  int servo_integral = 0;
  logic [63:0] servo_prev_off = '0;

  res_t servo_expect_q[$];
  script_row_t servo_script[$];
  res_t servo_got, servo_want;
  int servo_mismatches = 0;
  int idle_cycles = 0;
  int gap_pct = 20;
  int stall_pct = 10;
  bit quiet = 1'b0;

  ptp_pi_clock_servo_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] master_us(logic [47:0] secs, logic [31:0] ns);
    return 64'(secs) * US_PER_SEC + 64'(ns / 32'd1000);
  endfunction

  function automatic logic [62:0] local_for(logic [47:0] secs, logic [31:0] ns,
                                            logic [63:0] off);
    return 63'(master_us(secs, ns) - off);
  endfunction

  function automatic res_t mk_want(action_e a, logic [31:0] ss, logic [63:0] off, bit sync);
    res_t r;
    r = '0;
    r.action = a;
    r.set_seconds = ss;
    r.offset_us = off;
    r.synchronized = sync;
    return r;
  endfunction

  function automatic string fmt_res(res_t r);
    return $sformatf("act=%0d ss=%0d sns=%0d frq=%0d off=%0d jit=%0d sync=%0b",
                     r.action, r.set_seconds, r.set_nanoseconds,
                     $signed(r.freq_adjust_ppb), $signed(r.offset_us),
                     $signed(r.jitter_us), r.synchronized);
  endfunction

  function automatic res_t servo_predict(ptp_item_t it);
    res_t r;
    logic [63:0] master, off_u, mag;
    longint off, lim, maxa, acc, adj, kp, ki;
    r = '0;
    r.action = ACT_NONE;
    if (it.op == OP_RESYNC) begin
      servo_synced = 1'b0;
    end else if (it.len >= MIN_FRAME_LEN && (it.mtype == MSG_SYNC || it.mtype == MSG_FOLLOW_UP)
                 && it.secs > MIN_VALID_SECS) begin
      master = master_us(it.secs, it.ns);
      off_u = master - {1'b0, it.lcl};
      off = off_u;
      mag = (off < 0) ? (64'd0 - off_u) : off_u;
      if (!servo_synced || mag > {24'd0, cfg_stepthr}) begin
        r.action = ACT_SET;
        r.set_seconds = 32'(master / US_PER_SEC);
        r.set_nanoseconds = 30'((master % US_PER_SEC) * 64'd1000);
        servo_integral = 0;
      end else begin
        lim = cfg_intlim;
        maxa = cfg_maxadj;
        kp = cfg_prop;
        ki = cfg_int;
        acc = longint'(servo_integral) + off;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        servo_integral = int'(acc);
        adj = kp * off + ki * acc;
        if (adj > maxa) adj = maxa;
        if (adj < -maxa) adj = -maxa;
        r.action = ACT_ADJ;
        r.freq_adjust_ppb = adj[27:0];
      end
      r.jitter_us = (servo_prev_off == 64'd0) ? 64'd0 : off_u - servo_prev_off;
      servo_prev_off = off_u;
      r.offset_us = off_u;
      servo_synced = 1'b1;
    end
    r.synchronized = servo_synced;
    return r;
  endfunction

  function automatic void add_row(bit op, logic [7:0] len, logic [3:0] mtype,
                                  logic [47:0] secs, logic [31:0] ns, logic [62:0] lcl,
                                  bit typed, res_t want);
    script_row_t row;
    row.it.op = op;
    row.it.len = len;
    row.it.mtype = mtype;
    row.it.secs = secs;
    row.it.ns = ns;
    row.it.lcl = lcl;
    row.typed = typed;
    row.want = want;
    servo_script.push_back(row);
  endfunction

  function automatic ptp_item_t rand_item();
    ptp_item_t it;
    int pick, kind;
    logic [63:0] off, span;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.op = (pick < 8);
      it.len = 8'($urandom_range(0, 128));
      it.mtype = 4'($urandom);
      it.secs = 48'({$urandom, $urandom});
      it.ns = $urandom;
      it.lcl = 63'({$urandom, $urandom});
      return it;
    end
    it.op = 1'b0;
    it.len = 8'($urandom_range(44, 128));
    it.mtype = $urandom_range(0, 1) ? MSG_FOLLOW_UP : MSG_SYNC;
    if ($urandom_range(0, 9) == 0) begin
      it.secs = 48'({$urandom, $urandom});
      if (it.secs <= MIN_VALID_SECS) it.secs = it.secs + SECS0;
    end else begin
      it.secs = SECS0 + 48'($urandom_range(0, 1000000000));
    end
    it.ns = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 999999999));
    span = {24'd0, cfg_stepthr};
    kind = $urandom_range(0, 99);
    if (kind < 45) off = 64'($urandom_range(0, 2000));
    else if (kind < 75) off = {$urandom, $urandom} % (span + 64'd1);
    else if (kind < 83) off = span;
    else if (kind < 91) off = span + 64'd1;
    else off = {$urandom, $urandom};
    if ($urandom_range(0, 1)) off = 64'd0 - off;
    it.lcl = local_for(it.secs, it.ns, off);
    return it;
  endfunction

  task automatic send_item(ptp_item_t it, bit typed, res_t want);
    res_t exp;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, it.lcl, it.ns, it.secs, it.mtype, it.len};
    s_tuser <= it.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    exp = servo_predict(it);
    if (typed) exp = want;
    servo_expect_q.push_back(exp);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (servo_expect_q.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PROP_GAIN: cfg_prop = val[13:0];
      CFG_INT_GAIN:  cfg_int = val[13:0];
      CFG_MAX_ADJ:   cfg_maxadj = val[26:0];
      CFG_INT_LIMIT: cfg_intlim = val[29:0];
      CFG_STEP_THR:  cfg_stepthr = val[39:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [39:0] kp, logic [39:0] ki, logic [39:0] maxa,
                              logic [39:0] lim, logic [39:0] thr);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INT_GAIN, ki);
    write_reg(CFG_MAX_ADJ, maxa);
    write_reg(CFG_INT_LIMIT, lim);
    write_reg(CFG_STEP_THR, thr);
    cfg_valid <= 1'b0;
  endtask

  // output stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      servo_got.action = action_e'(m_axis_tuser_o);
      servo_got.set_seconds = m_axis_tdata_o[31:0];
      servo_got.set_nanoseconds = m_axis_tdata_o[61:32];
      servo_got.freq_adjust_ppb = m_axis_tdata_o[89:62];
      servo_got.offset_us = m_axis_tdata_o[153:90];
      servo_got.jitter_us = m_axis_tdata_o[217:154];
      servo_got.synchronized = m_axis_tdata_o[218];
      if (servo_expect_q.size() == 0) begin
        servo_mismatches++;
        if (servo_mismatches <= 10)
          $display("unexpected result item: %s", fmt_res(servo_got));
      end else begin
        servo_want = servo_expect_q.pop_front();
        if (servo_got.action !== servo_want.action ||
            servo_got.set_seconds !== servo_want.set_seconds ||
            servo_got.set_nanoseconds !== servo_want.set_nanoseconds ||
            servo_got.freq_adjust_ppb !== servo_want.freq_adjust_ppb ||
            servo_got.offset_us !== servo_want.offset_us ||
            servo_got.jitter_us !== servo_want.jitter_us ||
            servo_got.synchronized !== servo_want.synchronized) begin
          servo_mismatches++;
          if (servo_mismatches <= 10)
            $display("mismatch at %0t\n  exp %s\n  got %s", $realtime,
                     fmt_res(servo_want), fmt_res(servo_got));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
        (cfg_valid && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int k, ph;
    // after reset: rejected frames and resync
    add_row(0, 8'd43, MSG_SYNC, SECS0 + 48'd5, 0, 0, 1, mk_want(ACT_NONE, 0, 0, 0));
    add_row(0, 8'd44, 4'h1, SECS0, 0, 0, 1, mk_want(ACT_NONE, 0, 0, 0));
    add_row(0, 8'd128, MSG_FOLLOW_UP, MIN_VALID_SECS, 0, 0, 1, mk_want(ACT_NONE, 0, 0, 0));
    add_row(1, 8'd128, MSG_SYNC, SECS0, 32'hFFFFFFFF, '1, 1, mk_want(ACT_NONE, 0, 0, 0));
    // first qualifying frame sets the clock
    add_row(0, 8'd44, MSG_SYNC, SECS0, 0, 0, 1,
            mk_want(ACT_SET, 32'd1000000001, 64'd1000000001000000, 1));
    add_row(0, 8'd44, MSG_SYNC, SECS0, 500000, local_for(SECS0, 500000, 64'd500), 0, '0);
    add_row(0, 8'd60, MSG_FOLLOW_UP, SECS0, 7000, local_for(SECS0, 7000, 0), 0, '0);
    // zero previous offset gives zero jitter
    add_row(0, 8'd60, MSG_SYNC, SECS0, 9000, local_for(SECS0, 9000, 64'd10), 0, '0);
    add_row(0, 8'd64, MSG_SYNC, SECS0, 0, local_for(SECS0, 0, THR0), 0, '0);
    add_row(0, 8'd64, MSG_SYNC, SECS0, 0, local_for(SECS0, 0, THR0), 0, '0);
    add_row(0, 8'd64, MSG_SYNC, SECS0, 0, local_for(SECS0, 0, 64'd0 - THR0), 0, '0);
    add_row(0, 8'd64, MSG_SYNC, SECS0, 0, local_for(SECS0, 0, THR0 + 64'd1), 0, '0);
    add_row(0, 8'd64, MSG_SYNC, SECS0, 0, local_for(SECS0, 0, 64'd0 - THR0 - 64'd1), 0, '0);
    add_row(0, 8'd128, MSG_FOLLOW_UP, SECS0, 32'hFFFFFFFF,
            local_for(SECS0, 32'hFFFFFFFF, 64'd77), 0, '0);
    add_row(1, 8'd0, 4'hF, 0, 0, 0, 1, mk_want(ACT_NONE, 0, 0, 0));
    add_row(0, 8'd50, MSG_SYNC, SECS0, 1000, local_for(SECS0, 1000, 64'd3), 0, '0);
    add_row(0, 8'd128, MSG_SYNC, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 63'h7FFFFFFFFFFFFFFF, 0, '0);
    // most negative offset
    add_row(0, 8'd44, MSG_SYNC, 48'd10000000000000, 0,
            local_for(48'd10000000000000, 0, 64'h8000000000000000), 0, '0);
    add_row(0, 8'd44, MSG_SYNC, SECS0, 3000, local_for(SECS0, 3000, 64'd1), 0, '0);
    add_row(0, 8'd44, MSG_FOLLOW_UP, SECS0, 999999999, 0, 0, '0);
    add_row(0, 8'd0, 4'hF, 0, 0, 0, 1, mk_want(ACT_NONE, 0, 0, 1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < servo_script.size(); k++)
      send_item(servo_script[k].it, servo_script[k].typed, servo_script[k].want);

    for (ph = 1; ph <= 8; ph++) begin
      drain();
      case (ph)
        1: program_regs(0, 0, 0, 0, 0);
        2: program_regs(10000, 10000, 100000000, 1000000000, 40'd1000000000000);
        3: program_regs(100, 10, 1000000, 1000000, 1000000);
        default: begin
          program_regs($urandom_range(0, 10000), $urandom_range(0, 10000),
                       $urandom_range(0, 100000000), $urandom_range(0, 1000000000),
                       $urandom_range(0, 1) ? 40'($urandom_range(0, 5000))
                                            : 40'({$urandom, $urandom} % 64'd1000000000001));
        end
      endcase
      gap_pct = $urandom_range(0, 40);
      stall_pct = $urandom_range(0, 15);
      quiet = (ph == 8);
      for (k = 0; k < 190; k++) begin
        if (k == 95) drain();
        send_item(rand_item(), 1'b0, mk_want(ACT_NONE, 0, 0, 0));
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (servo_mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
